[hw/rtl/alrf_pkg.sv]
// shared types, constants and handshake structs for the audio loop recorder
// no dependencies; every other file but alrf_ram refers to this package by scoped names
`timescale 1ns / 1ps

package alrf_pkg;

	// memory geometry
	localparam int BUFFER_DEPTH = 65536;
	localparam int FADE_LEN     = 24;
	localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
	localparam int POS_W        = ADDR_W + 1;
	localparam int SAMPLE_W     = 16;

	// fade walk: fade-in entries first, then fade-out entries
	localparam int FI_CNT   = (FADE_LEN < BUFFER_DEPTH) ? FADE_LEN : BUFFER_DEPTH;
	localparam int FO_START = (FADE_LEN <= BUFFER_DEPTH) ? BUFFER_DEPTH - FADE_LEN : 0;
	localparam int FO_CNT   = BUFFER_DEPTH - FO_START;
	localparam int FADE_TOT = FI_CNT + FO_CNT;
	localparam int FCNT_W   = $clog2(FADE_TOT);

	// fade arithmetic: |s| * num, then divide by FADE_LEN through a reciprocal
	localparam int FADE_W  = $clog2(FADE_LEN + 1);
	localparam int NUM_W   = (SAMPLE_W - 1) + FADE_W;
	localparam int DIV_SH  = $clog2(FADE_LEN);
	localparam int RECIP_K = NUM_W + DIV_SH;
	localparam int RECIP_W = NUM_W + 1;
	localparam int PROD_W  = NUM_W + RECIP_W;
	localparam int QUO_W   = SAMPLE_W + 1;
	localparam longint unsigned RECIP_L =
		((64'd1 << RECIP_K) + FADE_LEN - 1) / FADE_LEN;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

	// item command codes
	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_START = 2'd1,
		MODE_STOP  = 2'd2,
		MODE_PLAY  = 2'd3
	} mode_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic fade_mul;
		logic fade_scl;
		logic fade_wr;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fade_req;
		logic fade_last;
	} dp_stat_t;

endpackage

[hw/rtl/audio_loop_recorder_with_fades.sv]
// Record-and-loop sample memory with fade-in and fade-out on the recorded loop.
// Input beat: start with mode and sample_in, taken at a clock edge where busy is low.
// Result beat: done is high for one cycle, the cycle after the input beat, carrying
//   sample_out, is_recording and is_playing; the receiver cannot hold it off.
// Start and play commands never raise busy, and a tick raises it only on a full memory while
//   recording, so ticks may arrive every cycle while playing or while recording until full.
// A stop that ends a recording, or a tick that finds the memory full, runs the fade walk
//   over 2*FADE_LEN entries, each taken through the read, multiply, reciprocal-scale and
//   write-back states in turn; busy stays high for the whole walk and its result beat
//   comes at once.
// The memory is never swept: a fill count marks how far the last recording reached,
//   and entries past it read as zero, so start and reset take effect at once.
// Reset (arst_n low) clears position, fill count and flags; the block is idle after it.
// Depends on alrf_pkg, alrf_ctrl, alrf_datapath and alrf_ram.
`timescale 1ns / 1ps

module audio_loop_recorder_with_fades (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [1:0]                          mode,
	input  logic signed [alrf_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                busy,
	output logic                                done,
	output logic signed [alrf_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                is_recording,
	output logic                                is_playing
);

	alrf_pkg::dp_cmd_t  cmd;
	alrf_pkg::dp_stat_t stat;

	alrf_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	alrf_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode),
		.sample_in   (sample_in),
		.cmd         (cmd),
		.stat        (stat),
		.sample_out  (sample_out),
		.is_recording(is_recording),
		.is_playing  (is_playing)
	);

endmodule

[hw/rtl/alrf_ram.sv]
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
`timescale 1ns / 1ps

module alrf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/alrf_datapath.sv]
// datapath: position and fill count, sample memory, fade arithmetic, result mux
// depends on alrf_pkg and alrf_ram
`timescale 1ns / 1ps

module alrf_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [1:0]                          mode,
	input  logic signed [alrf_pkg::SAMPLE_W-1:0] sample_in,
	input  alrf_pkg::dp_cmd_t                   cmd,
	output alrf_pkg::dp_stat_t                  stat,
	output logic signed [alrf_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                is_recording,
	output logic                                is_playing
);

	localparam int POS_W  = alrf_pkg::POS_W;
	localparam int ADDR_W = alrf_pkg::ADDR_W;
	localparam int SW     = alrf_pkg::SAMPLE_W;
	localparam int NUM_W  = alrf_pkg::NUM_W;
	localparam int FW     = alrf_pkg::FADE_W;
	localparam int CW     = alrf_pkg::FCNT_W;
	localparam int PW     = alrf_pkg::PROD_W;
	localparam int QW     = alrf_pkg::QUO_W;

	alrf_pkg::mode_t mode_e;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] fill_q;
	logic             rec_q;
	logic             play_q;
	logic             rd_use_q;
	logic [CW-1:0]    fk_q;
	logic             neg_q;
	logic [NUM_W-1:0] mag_q;
	logic [QW-1:0]    quo_q;

	logic             full;
	logic             is_tick;
	logic             rec_wr;
	logic             play_rd;
	logic [POS_W-1:0] pos_inc;
	logic             fade_in;
	logic [POS_W-1:0] faddr;
	logic [FW-1:0]    fnum;
	logic [SW-1:0]    rdata;
	logic [SW-1:0]    abs_s;
	logic [PW-1:0]    prod;
	logic [QW-1:0]    quo_neg;
	logic             ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [SW-1:0]    ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;

	// item decode
	always_comb begin
		mode_e  = alrf_pkg::mode_t'(mode);
		full    = (pos_q == POS_W'(alrf_pkg::BUFFER_DEPTH));
		is_tick = (mode_e == alrf_pkg::MODE_TICK);
		rec_wr  = cmd.accept && is_tick && rec_q && !full;
		play_rd = cmd.accept && is_tick && play_q;
		pos_inc = pos_q + POS_W'(1);
		stat.fade_req  = rec_q && ((mode_e == alrf_pkg::MODE_STOP) || (is_tick && full));
		stat.fade_last = (fk_q == CW'(alrf_pkg::FADE_TOT - 1));
	end

	// fade entry address and scale numerator
	always_comb begin
		fade_in = (fk_q < CW'(alrf_pkg::FI_CNT));
		if (fade_in) begin
			faddr = POS_W'(fk_q);
			fnum  = FW'(fk_q);
		end else begin
			faddr = POS_W'(alrf_pkg::FO_START) + POS_W'(fk_q) - POS_W'(alrf_pkg::FI_CNT);
			fnum  = FW'(POS_W'(alrf_pkg::BUFFER_DEPTH) - faddr);
		end
	end

	// fade arithmetic
	always_comb begin
		abs_s   = rdata[SW-1] ? (SW'(0) - rdata) : rdata;
		prod    = PW'(mag_q) * PW'(alrf_pkg::RECIP);
		quo_neg = QW'(0) - quo_q;
	end

	// memory port steering
	always_comb begin
		ram_we    = rec_wr || (cmd.fade_wr && (faddr < fill_q));
		ram_waddr = rec_wr ? pos_q[ADDR_W-1:0] : faddr[ADDR_W-1:0];
		ram_wdata = rec_wr ? sample_in : (neg_q ? quo_neg[SW-1:0] : quo_q[SW-1:0]);
		ram_raddr = play_rd ? pos_q[ADDR_W-1:0] : faddr[ADDR_W-1:0];
	end

	alrf_ram #(
		.WIDTH(SW),
		.DEPTH(alrf_pkg::BUFFER_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	// position, fill count and mode flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			fill_q   <= '0;
			rec_q    <= 1'b0;
			play_q   <= 1'b0;
			rd_use_q <= 1'b0;
		end else begin
			rd_use_q <= play_rd && (pos_q < fill_q);
			if (cmd.accept) begin
				unique case (mode_e)
					alrf_pkg::MODE_START: begin
						pos_q  <= '0;
						fill_q <= '0;
						rec_q  <= 1'b1;
						play_q <= 1'b0;
					end
					alrf_pkg::MODE_STOP: begin
						pos_q  <= '0;
						rec_q  <= 1'b0;
						play_q <= 1'b0;
					end
					alrf_pkg::MODE_PLAY: begin
						pos_q  <= '0;
						rec_q  <= 1'b0;
						play_q <= 1'b1;
					end
					default: begin
						if (rec_q) begin
							if (full) begin
								pos_q  <= '0;
								rec_q  <= 1'b0;
								play_q <= 1'b0;
							end else begin
								pos_q  <= pos_inc;
								fill_q <= pos_inc;
							end
						end else if (play_q) begin
							pos_q <= (pos_inc == POS_W'(alrf_pkg::BUFFER_DEPTH)) ? '0 : pos_inc;
						end
					end
				endcase
			end
		end
	end

	// fade walk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fk_q <= '0;
		end else if (cmd.accept) begin
			fk_q <= '0;
		end else if (cmd.fade_wr) begin
			fk_q <= fk_q + CW'(1);
		end
	end

	// fade pipeline registers
	always_ff @(posedge clk) begin
		if (cmd.fade_mul) begin
			neg_q <= rdata[SW-1];
			mag_q <= NUM_W'(abs_s) * NUM_W'(fnum);
		end
		if (cmd.fade_scl) begin
			quo_q <= prod[alrf_pkg::RECIP_K +: QW];
		end
	end

	// result fields
	assign sample_out   = rd_use_q ? rdata : '0;
	assign is_recording = rec_q;
	assign is_playing   = play_q;

endmodule

[hw/rtl/alrf_ctrl.sv]
// controller: accepts items, sequences the fade walk, raises busy and the result strobe
// depends on alrf_pkg
`timescale 1ns / 1ps

module alrf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  alrf_pkg::dp_stat_t stat,
	output alrf_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               done
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_SCL  = 5'b01000,
		ST_WR   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   done_q;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && stat.fade_req) begin
					state_nx = ST_RD;
				end
			end
			ST_RD:  state_nx = ST_MUL;
			ST_MUL: state_nx = ST_SCL;
			ST_SCL: state_nx = ST_WR;
			ST_WR:  state_nx = stat.fade_last ? ST_IDLE : ST_RD;
			default: state_nx = ST_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		busy         = (state_q != ST_IDLE);
		cmd.accept   = start && !busy;
		cmd.fade_mul = (state_q == ST_MUL);
		cmd.fade_scl = (state_q == ST_SCL);
		cmd.fade_wr  = (state_q == ST_WR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= cmd.accept;
		end
	end

	assign done = done_q;

endmodule

[hw/rtl/alrf_checker.sv]
// port-level checks for the audio loop recorder, bound to the top level
// depends on alrf_pkg and audio_loop_recorder_with_fades
`timescale 1ns / 1ps

module alrf_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic [1:0]                          mode,
	input logic                                busy,
	input logic                                done,
	input logic signed [alrf_pkg::SAMPLE_W-1:0] sample_out,
	input logic                                is_recording,
	input logic                                is_playing
);

	// every input beat gets its result beat in the next cycle
	a_beat_answered: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("input beat without result beat");

	// no result beat without an input beat just before
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result beat without input beat");

	// recording and playing never hold together in a result beat
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(is_recording && is_playing))
		else $error("recording and playing both set");

	// silence when not playing
	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !is_playing) |-> (sample_out == '0))
		else $error("nonzero sample while not playing");

	// a start command always leaves the block recording
	a_start_records: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(mode) == alrf_pkg::MODE_START)) |-> (is_recording && !is_playing))
		else $error("start did not begin recording");

endmodule

bind audio_loop_recorder_with_fades alrf_checker u_alrf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.mode        (mode),
	.busy        (busy),
	.done        (done),
	.sample_out  (sample_out),
	.is_recording(is_recording),
	.is_playing  (is_playing)
);
